// ----- rtl/srs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// shared types and constants of the score ranking sorter
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int SCORE_W         = 16;
    localparam int TAG_W           = 5;
    localparam int RANK_W          = 5;
    localparam int LIMIT_W         = 5;
    localparam int REC_W           = SCORE_W + TAG_W;
    localparam int MAX_SHOWN       = 16;
    localparam int MAX_ENTRIES_DEF = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/score_ranking_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// score_ranking_sorter
// stable descending ranking of a set of score records, top k emitted
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one record per transaction (score, tag), s_tlast marks
//   the last record of a set. records are written to the record memory in
//   load order at one per cycle; records beyond MAX_ENTRIES are dropped.
//   the transaction with s_tlast high closes the set and starts ranking;
//   s_tready stays low until the last ranked record has been placed on m_.
//   ranking runs as repeated passes over the memory through its single
//   read port: each pass reads every held record once and finds the next
//   record in (score desc, load order), one pass per result.
//   m_ channel carries rank, tag and score; m_tlast marks the last result.
//   up to min(n, show_limit) results are produced, show_limit clamped to
//   1..16. a stalled m_tready holds the output register; the next pass
//   still runs and its result waits for the register. cfg_ writes
//   show_limit at any time, it is sampled when the closing record is
//   accepted.
//   reset (aresetn low, synchronous) empties the set, sets show_limit to 10
//   and drops any pending result.
// ----------------------------------------------------------------------------
module score_ranking_sorter #(
    parameter int MAX_ENTRIES = srs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: [15:0] entry_score, [20:16] entry_tag, [23:21] zero
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,
    input  logic                        s_tlast,
    // m_tdata: [4:0] rank, [9:5] ranked_tag, [25:10] ranked_score, [31:26] zero
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    output logic                        m_tlast,
    // cfg_data: show_limit
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [srs_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = srs_pkg::SCORE_W + IW;
    localparam int SW = (CW > srs_pkg::LIMIT_W) ? CW : srs_pkg::LIMIT_W;
    localparam int RW = srs_pkg::RANK_W;

    srs_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 held_reg;
    logic [srs_pkg::LIMIT_W-1:0]   limit_reg;
    logic [RW-1:0]                 shown_reg;
    logic [RW-1:0]                 rank_reg;
    logic                          first_reg;
    logic [KW-1:0]                 prev_key_reg;
    logic [KW-1:0]                 best_key_reg;
    logic [srs_pkg::TAG_W-1:0]     best_tag_reg;
    logic                          best_found_reg;
    logic [CW-1:0]                 issue_reg;
    logic                          rd_pend_reg;
    logic [IW-1:0]                 rd_idx_reg;
    logic                          m_valid_reg;
    logic [RW-1:0]                 out_rank_reg;
    logic [srs_pkg::TAG_W-1:0]     out_tag_reg;
    logic [srs_pkg::SCORE_W-1:0]   out_score_reg;
    logic                          out_last_reg;

    logic                          in_acc;
    logic                          room;
    logic [CW-1:0]                 held_after;
    logic [srs_pkg::LIMIT_W-1:0]   lim_c;
    logic [RW-1:0]                 shown_calc;
    logic                          issue_go;
    logic                          scan_done;
    logic                          emit;
    logic                          last_rank;
    logic [srs_pkg::REC_W-1:0]     rd_data;
    logic [srs_pkg::SCORE_W-1:0]   rd_score;
    logic [srs_pkg::TAG_W-1:0]     rd_tag;
    logic [KW-1:0]                 cand_key;
    logic                          take;

    srs_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW),
        .DW    (srs_pkg::REC_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_acc && room),
        .wr_addr (held_reg[IW-1:0]),
        .wr_data (s_tdata[srs_pkg::REC_W-1:0]),
        .rd_en   (issue_go),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == srs_pkg::ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign room      = (held_reg < CW'(MAX_ENTRIES));
    assign held_after = held_reg + CW'(room);

    always_comb begin
        if (limit_reg == '0) begin
            lim_c = srs_pkg::LIMIT_W'(1);
        end else if (limit_reg > srs_pkg::LIMIT_W'(srs_pkg::MAX_SHOWN)) begin
            lim_c = srs_pkg::LIMIT_W'(srs_pkg::MAX_SHOWN);
        end else begin
            lim_c = limit_reg;
        end
        if (SW'(held_after) < SW'(lim_c)) begin
            shown_calc = RW'(held_after);
        end else begin
            shown_calc = RW'(lim_c);
        end
    end

    // record key: higher score first, then lower load index
    assign rd_score = rd_data[srs_pkg::SCORE_W-1:0];
    assign rd_tag   = rd_data[srs_pkg::REC_W-1:srs_pkg::SCORE_W];
    assign cand_key = {rd_score, ~rd_idx_reg};
    assign take     = rd_pend_reg && (first_reg || (cand_key < prev_key_reg))
                      && (!best_found_reg || (cand_key > best_key_reg));

    assign issue_go  = (state_reg == srs_pkg::ST_SCAN) && (issue_reg != held_reg);
    assign scan_done = (state_reg == srs_pkg::ST_SCAN) && (issue_reg == held_reg)
                       && !rd_pend_reg;
    assign last_rank = (rank_reg == shown_reg);
    assign emit      = (state_reg == srs_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srs_pkg::ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = srs_pkg::ST_SCAN;
                end
            end
            srs_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = srs_pkg::ST_EMIT;
                end
            end
            srs_pkg::ST_EMIT: begin
                if (emit) begin
                    state_next = last_rank ? srs_pkg::ST_LOAD : srs_pkg::ST_SCAN;
                end
            end
            default: state_next = srs_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srs_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg       <= '0;
            limit_reg      <= srs_pkg::LIMIT_RESET;
            m_valid_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            first_reg      <= 1'b1;
            issue_reg      <= '0;
            rank_reg       <= RW'(1);
            shown_reg      <= RW'(1);
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            if (in_acc) begin
                held_reg <= held_after;
                if (s_tlast) begin
                    shown_reg      <= shown_calc;
                    rank_reg       <= RW'(1);
                    first_reg      <= 1'b1;
                    issue_reg      <= '0;
                    best_found_reg <= 1'b0;
                end
            end
            rd_pend_reg <= issue_go;
            if (issue_go) begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (take) begin
                best_found_reg <= 1'b1;
            end
            if (emit) begin
                m_valid_reg    <= 1'b1;
                first_reg      <= 1'b0;
                rank_reg       <= rank_reg + RW'(1);
                issue_reg      <= '0;
                best_found_reg <= 1'b0;
                if (last_rank) begin
                    held_reg <= '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= issue_reg[IW-1:0];
        if (take) begin
            best_key_reg <= cand_key;
            best_tag_reg <= rd_tag;
        end
        if (emit) begin
            prev_key_reg  <= best_key_reg;
            out_rank_reg  <= rank_reg;
            out_tag_reg   <= best_tag_reg;
            out_score_reg <= best_key_reg[KW-1:IW];
            out_last_reg  <= last_rank;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_score_reg, out_tag_reg, out_rank_reg};

    // a pass always finds a record, since ranks never exceed the records held
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> best_found_reg)
        else $error("ranking pass ended without a record");

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CW'(MAX_ENTRIES))
        else $error("held count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != srs_pkg::ST_LOAD) |-> (rank_reg <= shown_reg)
            && (shown_reg != '0) && (RW'(shown_reg) <= RW'(srs_pkg::MAX_SHOWN)))
        else $error("rank counter beyond result count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_rank) |=> (state_reg == srs_pkg::ST_LOAD) && (held_reg == '0))
        else $error("set not cleared after last result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !first_reg) |-> (best_key_reg < prev_key_reg))
        else $error("results not in descending order");

endmodule

// ----- rtl/srs_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_store
// record memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module srs_store #(
    parameter int DEPTH = srs_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(srs_pkg::MAX_ENTRIES_DEF),
    parameter int DW    = srs_pkg::REC_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
